[rtl/core/lp2p_pkg.sv]
// lidar point to pixel projection: shared widths, payload types, register indexes
// no dependencies
`timescale 1ns / 1ps

package lp2p_pkg;

  localparam int CoordW   = 24;
  localparam int TermW    = 16;
  localparam int PixW     = 16;
  localparam int ProdW    = CoordW + TermW;
  localparam int RowSumW  = CoordW + 18;
  localparam int CamW     = CoordW + 4;
  localparam int FProdW   = CamW + 17;
  localparam int HalfSumW = CamW + 18;
  localparam int NumW     = CamW + 35;
  localparam int SclW     = CamW + 18;
  localparam int RemW     = CamW + 16;
  localparam int DepW     = CamW - 1;
  localparam int DivSteps = PixW;
  localparam int CfgIdxW  = 8;

  localparam logic [CfgIdxW-1:0] CfgRotX   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgRotY   = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgRotZ   = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgFocal  = 8'd3;
  localparam logic [CfgIdxW-1:0] CfgPrinc  = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgImage  = 8'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_col;
    logic [PixW-1:0] pixel_row;
    logic            visible;
  } pixel_t;

  typedef struct packed {
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_z;
  } xform_cfg_t;

  typedef struct packed {
    logic [31:0]     fx;
    logic [31:0]     fy;
    logic [31:0]     cx;
    logic [31:0]     cy;
    logic [PixW-1:0] width;
    logic [PixW-1:0] height;
  } intr_cfg_t;

  typedef struct packed {
    logic signed [CamW-1:0] cam_x;
    logic signed [CamW-1:0] cam_y;
    logic signed [CamW-1:0] cam_z;
  } cam_t;

  typedef struct packed {
    logic            vis;
    logic [RemW-1:0] rem_c;
    logic [RemW-1:0] rem_r;
    logic [DepW-1:0] dep;
  } div_in_t;

endpackage

[rtl/core/lp2p_xform.sv]
// rigid transform of a lidar point into the camera frame, two register stages
// depends on lp2p_pkg
`timescale 1ns / 1ps

module lp2p_xform
  import lp2p_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  xform_cfg_t cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  point_t     in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cam_t       out_data
);

  logic [63:0]              rows [3];
  logic signed [CoordW-1:0] pt   [3];
  logic signed [ProdW-1:0]  prod_nxt [3][3];
  logic signed [ProdW-1:0]  prod_r   [3][3];
  logic signed [CamW-1:0]   cam_nxt  [3];
  logic signed [CamW-1:0]   cam_r    [3];
  logic                     v1_r, v2_r, en1, en2;

  assign rows[0] = cfg.row_x;
  assign rows[1] = cfg.row_y;
  assign rows[2] = cfg.row_z;
  assign pt[0]   = in_data.point_x;
  assign pt[1]   = in_data.point_y;
  assign pt[2]   = in_data.point_z;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // stage 1: nine rotation products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = $signed(rows[i][63-16*j -: TermW]) * pt[j];
      end
    end
  end

  // stage 2: row sums, floor by 2^14, translation
  always_comb begin
    logic signed [RowSumW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum = RowSumW'(prod_r[i][0]) + RowSumW'(prod_r[i][1]) + RowSumW'(prod_r[i][2]);
      cam_nxt[i] = CamW'(sum >>> 14) + CamW'($signed(rows[i][TermW-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) prod_r <= prod_nxt;
    if (en2) cam_r <= cam_nxt;
  end

  assign out_valid      = v2_r;
  assign out_data.cam_x = cam_r[0];
  assign out_data.cam_y = cam_r[1];
  assign out_data.cam_z = cam_r[2];

endmodule

[rtl/core/lp2p_proj.sv]
// pinhole intrinsics, scaled numerators and bounds check, three register stages
// depends on lp2p_pkg
`timescale 1ns / 1ps

module lp2p_proj
  import lp2p_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  intr_cfg_t cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  cam_t      in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output div_in_t   out_data
);

  logic v3_r, v4_r, v5_r, en3, en4, en5;

  // stage 3 registers
  logic signed [FProdW-1:0] fhx_r, flx_r, khx_r, klx_r;
  logic signed [FProdW-1:0] fhy_r, fly_r, khy_r, kly_r;
  logic signed [FProdW-1:0] lzc_r, lzr_r;
  logic signed [CamW-1:0]   z3_r;

  // stage 4 registers
  logic signed [SclW-1:0]   sc_r, sc2_r, sr_r, sr2_r;
  logic signed [FProdW-1:0] lzc4_r, lzr4_r;
  logic signed [CamW-1:0]   z4_r;

  // stage 5 registers
  div_in_t                  d5_r;
  div_in_t                  d5_nxt;

  logic signed [SclW-1:0]   sc_nxt, sc2_nxt, sr_nxt, sr2_nxt;
  logic signed [HalfSumW-1:0] ax, bx, ay, by;
  logic signed [NumW-1:0]   nx, ny;
  logic                     okc, okr;

  assign en5      = !v5_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign in_ready = en3;

  // stage 4: numerators scaled by 2^-16, floor and negated floor
  assign ax = HalfSumW'(fhx_r) + HalfSumW'(khx_r);
  assign bx = HalfSumW'(flx_r) + HalfSumW'(klx_r);
  assign ay = HalfSumW'(fhy_r) + HalfSumW'(khy_r);
  assign by = HalfSumW'(fly_r) + HalfSumW'(kly_r);
  assign nx = (NumW'(ax) <<< 16) + NumW'(bx);
  assign ny = (NumW'(ay) <<< 16) + NumW'(by);
  assign sc_nxt  = SclW'(nx >>> 16);
  assign sc2_nxt = SclW'((-nx) >>> 16);
  assign sr_nxt  = SclW'(ny >>> 16);
  assign sr2_nxt = SclW'((-ny) >>> 16);

  // stage 5: bounds, a small negative fraction still lands on pixel 0
  always_comb begin
    if (sc_r >= 0) begin
      okc = sc_r < SclW'(lzc4_r);
    end else begin
      okc = (sc2_r < SclW'(z4_r)) && (cfg.width != '0);
    end
    if (sr_r >= 0) begin
      okr = sr_r < SclW'(lzr4_r);
    end else begin
      okr = (sr2_r < SclW'(z4_r)) && (cfg.height != '0);
    end
    d5_nxt.vis   = (z4_r > 0) && okc && okr;
    d5_nxt.rem_c = (sc_r >= 0) ? RemW'(sc_r) : '0;
    d5_nxt.rem_r = (sr_r >= 0) ? RemW'(sr_r) : '0;
    d5_nxt.dep   = DepW'(z4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en3) v3_r <= in_valid;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      fhx_r <= $signed({1'b0, cfg.fx[31:16]}) * in_data.cam_x;
      flx_r <= $signed({1'b0, cfg.fx[15:0]})  * in_data.cam_x;
      khx_r <= $signed({1'b0, cfg.cx[31:16]}) * in_data.cam_z;
      klx_r <= $signed({1'b0, cfg.cx[15:0]})  * in_data.cam_z;
      fhy_r <= $signed({1'b0, cfg.fy[31:16]}) * in_data.cam_y;
      fly_r <= $signed({1'b0, cfg.fy[15:0]})  * in_data.cam_y;
      khy_r <= $signed({1'b0, cfg.cy[31:16]}) * in_data.cam_z;
      kly_r <= $signed({1'b0, cfg.cy[15:0]})  * in_data.cam_z;
      lzc_r <= $signed({1'b0, cfg.width})     * in_data.cam_z;
      lzr_r <= $signed({1'b0, cfg.height})    * in_data.cam_z;
      z3_r  <= in_data.cam_z;
    end
    if (en4) begin
      sc_r   <= sc_nxt;
      sc2_r  <= sc2_nxt;
      sr_r   <= sr_nxt;
      sr2_r  <= sr2_nxt;
      lzc4_r <= lzc_r;
      lzr4_r <= lzr_r;
      z4_r   <= z3_r;
    end
    if (en5) d5_r <= d5_nxt;
  end

  assign out_valid = v5_r;
  assign out_data  = d5_r;

endmodule

[rtl/core/lp2p_div.sv]
// pipelined restoring divider, one quotient bit per stage for column and row
// depends on lp2p_pkg
`timescale 1ns / 1ps

module lp2p_div
  import lp2p_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  div_in_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output pixel_t  out_data
);

  logic                v_r   [DivSteps];
  logic                vis_r [DivSteps];
  logic [RemW-1:0]     rc_r  [DivSteps];
  logic [RemW-1:0]     rr_r  [DivSteps];
  logic [DepW-1:0]     dep_r [DivSteps];
  logic [PixW-1:0]     qc_r  [DivSteps];
  logic [PixW-1:0]     qr_r  [DivSteps];
  logic [DivSteps:0]   en;

  assign en[DivSteps] = out_ready;
  assign in_ready     = en[0];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic            v_in, vis_in, tc, tr;
    logic [RemW-1:0] rc_in, rr_in, sh;
    logic [DepW-1:0] dep_in;
    logic [PixW-1:0] qc_in, qr_in;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign vis_in = in_data.vis;
      assign rc_in  = in_data.rem_c;
      assign rr_in  = in_data.rem_r;
      assign dep_in = in_data.dep;
      assign qc_in  = '0;
      assign qr_in  = '0;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign vis_in = vis_r[k-1];
      assign rc_in  = rc_r[k-1];
      assign rr_in  = rr_r[k-1];
      assign dep_in = dep_r[k-1];
      assign qc_in  = qc_r[k-1];
      assign qr_in  = qr_r[k-1];
    end

    assign en[k] = !v_r[k] || en[k+1];
    assign sh    = RemW'(dep_in) << (DivSteps - 1 - k);
    assign tc    = rc_in >= sh;
    assign tr    = rr_in >= sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        vis_r[k] <= vis_in;
        dep_r[k] <= dep_in;
        rc_r[k]  <= tc ? rc_in - sh : rc_in;
        rr_r[k]  <= tr ? rr_in - sh : rr_in;
        qc_r[k]  <= {qc_in[PixW-2:0], tc};
        qr_r[k]  <= {qr_in[PixW-2:0], tr};
      end
    end
  end

  assign out_valid          = v_r[DivSteps-1];
  assign out_data.visible   = vis_r[DivSteps-1];
  assign out_data.pixel_col = vis_r[DivSteps-1] ? qc_r[DivSteps-1] : '0;
  assign out_data.pixel_row = vis_r[DivSteps-1] ? qr_r[DivSteps-1] : '0;

endmodule

[rtl/core/lidar_point_to_pixel_projection.sv]
// top level of the lidar point to pixel projection: config registers and pipeline
// depends on lp2p_pkg, lp2p_xform, lp2p_proj, lp2p_div
//
//   port group   direction  handshake                  payload
//   in_*         input      in_valid / in_stall        point_t (x, y, z)
//   out_*        output     out_valid / out_stall      pixel_t (col, row, visible)
//   cfg_*        input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one point per cycle sustained while out_stall is low; 2 transform stages,
// 3 projection stages, 16 divider stages, one quotient bit each
// rst_n is synchronous; it empties the pipeline and loads identity transform,
// unit focal lengths, zero principal point and a 1920 x 1080 image
// a stalled result holds; stages behind it keep filling bubbles before in_stall rises
`timescale 1ns / 1ps

module lidar_point_to_pixel_projection
  import lp2p_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  point_t             in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pixel_t             out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] rot_x_r, rot_y_r, rot_z_r, focal_r, princ_r;
  logic [31:0] image_r;

  xform_cfg_t xcfg;
  intr_cfg_t  icfg;
  logic       xf_ready, xf_valid, pj_ready, pj_valid, dv_ready;
  logic       pj_rdy_dv;
  cam_t       xf_data;
  div_in_t    pj_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r <= 64'h4000_0000_0000_0000;
      rot_y_r <= 64'h0000_4000_0000_0000;
      rot_z_r <= 64'h0000_0000_4000_0000;
      focal_r <= 64'h0001_0000_0001_0000;
      princ_r <= '0;
      image_r <= {16'd1920, 16'd1080};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgRotX:  rot_x_r <= cfg_data;
        CfgRotY:  rot_y_r <= cfg_data;
        CfgRotZ:  rot_z_r <= cfg_data;
        CfgFocal: focal_r <= cfg_data;
        CfgPrinc: princ_r <= cfg_data;
        CfgImage: image_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign xcfg.row_x  = rot_x_r;
  assign xcfg.row_y  = rot_y_r;
  assign xcfg.row_z  = rot_z_r;
  assign icfg.fx     = focal_r[63:32];
  assign icfg.fy     = focal_r[31:0];
  assign icfg.cx     = princ_r[63:32];
  assign icfg.cy     = princ_r[31:0];
  assign icfg.width  = image_r[31:16];
  assign icfg.height = image_r[15:0];

  assign in_stall = !xf_ready;
  assign dv_ready = !out_stall;

  lp2p_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (xcfg),
    .in_valid  (in_valid),
    .in_ready  (xf_ready),
    .in_data   (in_data),
    .out_valid (xf_valid),
    .out_ready (pj_ready),
    .out_data  (xf_data)
  );

  lp2p_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (icfg),
    .in_valid  (xf_valid),
    .in_ready  (pj_ready),
    .in_data   (xf_data),
    .out_valid (pj_valid),
    .out_ready (pj_rdy_dv),
    .out_data  (pj_data)
  );

  lp2p_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pj_valid),
    .in_ready  (pj_rdy_dv),
    .in_data   (pj_data),
    .out_valid (out_valid),
    .out_ready (dv_ready),
    .out_data  (out_data)
  );

endmodule
